@@ hdl/nisd_pkg.sv @@
// Shared types, constants and the control store for the NEC sample decoder.
`default_nettype none

package nisd_pkg;

  localparam int STORE_DEPTH  = 128;
  localparam int CNT_W        = $clog2(STORE_DEPTH);
  localparam int FRAME_PULSES = 32 * 2 + 1 + 2;
  localparam int IDX_W        = $clog2(FRAME_PULSES);
  localparam int LAST_IDX     = FRAME_PULSES - 1;
  localparam int SAMPLE_W     = 8;
  localparam int REG_W        = 8;
  localparam int CODE_W       = 32;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int STEP_W       = 3;

  localparam logic [REG_W-1:0] THRESHOLD_RST = 8'd64;
  localparam logic [REG_W-1:0] START_RST     = 8'd20;
  localparam logic [REG_W-1:0] GAP_RST       = 8'd250;
  localparam logic [REG_W-1:0] LMARK_RST     = 8'd135;
  localparam logic [REG_W-1:0] LSPACE_RST    = 8'd59;
  localparam logic [REG_W-1:0] SPLIT_RST     = 8'd26;
  localparam logic [REG_W-1:0] RUN_MAX       = 8'hff;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_START     = 3'd1,
    REG_GAP       = 3'd2,
    REG_LMARK     = 3'd3,
    REG_LSPACE    = 3'd4,
    REG_SPLIT     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] threshold;
    logic [REG_W-1:0] start_samples;
    logic [REG_W-1:0] gap_samples;
    logic [REG_W-1:0] leader_mark_min;
    logic [REG_W-1:0] leader_space_min;
    logic [REG_W-1:0] bit_split;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_e;

  typedef enum logic [STEP_W-1:0] {
    S_WAIT  = 3'd0,
    S_CLASS = 3'd1,
    S_INIT  = 3'd2,
    S_RD    = 3'd3,
    S_CHK   = 3'd4,
    S_FIN   = 3'd5,
    S_EMIT  = 3'd6,
    S_BACK  = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_IN     = 3'd2,
    C_NO_END    = 3'd3,
    C_WALK_MORE = 3'd4,
    C_OUT_BUSY  = 3'd5
  } cond_e;

  typedef struct packed {
    logic take;
    logic classify;
    logic init;
    logic check;
    logic finish;
    logic emit;
  } act_t;

  typedef struct packed {
    act_t  act;
    cond_e cond;
    step_e target;
  } ucode_t;

  typedef struct packed {
    logic in_avail;
    logic frame_end;
    logic walk_more;
    logic out_busy;
  } status_t;

  // Control store: on a true condition jump to target, else advance one step.
  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w = '{act: '0, cond: C_NEVER, target: S_WAIT};
    unique case (s)
      S_WAIT: begin
        w.act.take = 1'b1;
        w.cond     = C_NO_IN;
        w.target   = S_WAIT;
      end
      S_CLASS: begin
        w.act.classify = 1'b1;
        w.cond         = C_NO_END;
        w.target       = S_EMIT;
      end
      S_INIT: begin
        w.act.init = 1'b1;
      end
      S_RD: begin
        w.cond = C_NEVER;
      end
      S_CHK: begin
        w.act.check = 1'b1;
        w.cond      = C_WALK_MORE;
        w.target    = S_RD;
      end
      S_FIN: begin
        w.act.finish = 1'b1;
      end
      S_EMIT: begin
        w.act.emit = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.target   = S_EMIT;
      end
      S_BACK: begin
        w.cond   = C_ALWAYS;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/nisd_cfg.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module nisd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nisd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [nisd_pkg::DATA_W-1:0]   pwdata,
  output logic      [nisd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output nisd_pkg::cfg_t                     cfg_o
);
  import nisd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold        <= THRESHOLD_RST;
      cfg_q.start_samples    <= START_RST;
      cfg_q.gap_samples      <= GAP_RST;
      cfg_q.leader_mark_min  <= LMARK_RST;
      cfg_q.leader_space_min <= LSPACE_RST;
      cfg_q.bit_split        <= SPLIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_THRESHOLD: cfg_q.threshold        <= pwdata[REG_W-1:0];
        REG_START:     cfg_q.start_samples    <= pwdata[REG_W-1:0];
        REG_GAP:       cfg_q.gap_samples      <= pwdata[REG_W-1:0];
        REG_LMARK:     cfg_q.leader_mark_min  <= pwdata[REG_W-1:0];
        REG_LSPACE:    cfg_q.leader_space_min <= pwdata[REG_W-1:0];
        REG_SPLIT:     cfg_q.bit_split        <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg_q.threshold);
      REG_START:     prdata = DATA_W'(cfg_q.start_samples);
      REG_GAP:       prdata = DATA_W'(cfg_q.gap_samples);
      REG_LMARK:     prdata = DATA_W'(cfg_q.leader_mark_min);
      REG_LSPACE:    prdata = DATA_W'(cfg_q.leader_space_min);
      REG_SPLIT:     prdata = DATA_W'(cfg_q.bit_split);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/nisd_seq.sv @@
// Step counter and control store lookup with conditional jumps.
`default_nettype none

module nisd_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nisd_pkg::status_t status_i,
  output nisd_pkg::act_t         act_o
);
  import nisd_pkg::*;

  step_e               step_q, step_d;
  ucode_t              word;
  logic                jump;
  logic [STEP_W-1:0]   step_inc;

  assign word     = ucode_rom(step_q);
  assign act_o    = word.act;
  assign step_inc = step_q + 1'b1;

  always_comb begin
    unique case (word.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_IN:     jump = !status_i.in_avail;
      C_NO_END:    jump = !status_i.frame_end;
      C_WALK_MORE: jump = status_i.walk_more;
      C_OUT_BUSY:  jump = status_i.out_busy;
      default:     jump = 1'b0;
    endcase
    step_d = jump ? word.target : step_e'(step_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nisd_dp.sv @@
// Datapath: sample capture, run tracking, pulse store, frame walk and result register.
`default_nettype none

module nisd_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire nisd_pkg::cfg_t                  cfg_i,
  input  wire nisd_pkg::act_t                  act_i,
  output nisd_pkg::status_t                    status_o,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [nisd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 busy_res_o,
  output logic                                 frame_done_o,
  output logic                                 code_valid_o,
  output logic      [nisd_pkg::CODE_W-1:0]     code_o
);
  import nisd_pkg::*;

  logic [SAMPLE_W-1:0] sample_q;
  phase_e              phase_q, phase_d;
  logic [REG_W-1:0]    run_q, run_d, run_inc;
  logic [CNT_W-1:0]    pcnt_q, pcnt_d, pcnt_inc;
  logic                mark, wr_d, busy_d, end_d;

  logic [REG_W-1:0]    mem [STORE_DEPTH];
  logic [REG_W-1:0]    rd_q;

  logic [IDX_W-1:0]    idx_q;
  logic [CODE_W-1:0]   cmd_q, cmd_d;
  logic                prev_q, prev_d, fail_q, fail_d, cur, ok;

  logic                res_busy_q, res_done_q, res_valid_q;
  logic [CODE_W-1:0]   res_code_q;
  logic                out_busy;

  assign in_stall_o = !act_i.take;
  assign out_busy   = out_valid_o && out_stall_i;

  assign status_o.in_avail  = in_valid_i;
  assign status_o.frame_end = end_d;
  assign status_o.walk_more = idx_q != IDX_W'(LAST_IDX);
  assign status_o.out_busy  = out_busy;

  // Run and phase update for the captured sample.
  assign mark     = sample_q < cfg_i.threshold;
  assign run_inc  = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
  assign pcnt_inc = (pcnt_q == CNT_W'(STORE_DEPTH - 1)) ? '0 : pcnt_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    pcnt_d  = pcnt_q;
    wr_d    = 1'b0;
    busy_d  = 1'b0;
    end_d   = 1'b0;
    unique case (phase_q)
      PH_MARK: begin
        busy_d = 1'b1;
        if (mark) begin
          run_d = run_inc;
        end else begin
          wr_d    = 1'b1;
          run_d   = '0;
          pcnt_d  = pcnt_inc;
          phase_d = PH_SPACE;
        end
      end
      PH_SPACE: begin
        busy_d = 1'b1;
        if (!mark) begin
          if (run_inc > cfg_i.gap_samples) begin
            phase_d = PH_IDLE;
            run_d   = '0;
            busy_d  = 1'b0;
            end_d   = 1'b1;
          end else begin
            run_d = run_inc;
          end
        end else begin
          wr_d    = 1'b1;
          run_d   = '0;
          pcnt_d  = pcnt_inc;
          phase_d = PH_MARK;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (mark) begin
          run_d = run_inc;
          if (run_inc >= cfg_i.start_samples) begin
            phase_d = PH_MARK;
            pcnt_d  = '0;
            busy_d  = 1'b1;
          end
        end else begin
          run_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      run_q   <= '0;
      pcnt_q  <= '0;
    end else if (act_i.classify) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      pcnt_q  <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i.take && in_valid_i) begin
      sample_q <= sample_i;
    end
  end

  // Pulse store: one write port, one registered read port at the walk index.
  always_ff @(posedge clk_i) begin
    if (act_i.classify && wr_d) begin
      mem[pcnt_q] <= run_q;
    end
    rd_q <= mem[CNT_W'(idx_q)];
  end

  // Per-entry check during the frame walk.
  always_comb begin
    cmd_d  = cmd_q;
    prev_d = prev_q;
    fail_d = fail_q;
    cur    = rd_q >= cfg_i.bit_split;
    if (idx_q == IDX_W'(0)) begin
      if (rd_q < cfg_i.leader_mark_min) fail_d = 1'b1;
    end else if (idx_q == IDX_W'(1)) begin
      if (rd_q < cfg_i.leader_space_min) fail_d = 1'b1;
    end else if (idx_q == IDX_W'(LAST_IDX)) begin
      if (rd_q > cfg_i.leader_space_min) fail_d = 1'b1;
    end else if (idx_q[0]) begin
      // space carries the bit; a long mark before it spoils the frame
      if (prev_q) fail_d = 1'b1;
      cmd_d = {cur, cmd_q[CODE_W-1:1]};
    end else begin
      prev_d = cur;
    end
  end

  assign ok = !fail_q && (cmd_q[31:24] == ~cmd_q[23:16]);

  always_ff @(posedge clk_i) begin
    if (act_i.init) begin
      idx_q  <= '0;
      cmd_q  <= '0;
      prev_q <= 1'b0;
      fail_q <= pcnt_q != CNT_W'(FRAME_PULSES);
    end else if (act_i.check) begin
      idx_q  <= idx_q + 1'b1;
      cmd_q  <= cmd_d;
      prev_q <= prev_d;
      fail_q <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i.classify) begin
      res_busy_q  <= busy_d;
      res_done_q  <= end_d;
      res_valid_q <= 1'b0;
      res_code_q  <= '0;
    end else if (act_i.finish) begin
      res_valid_q <= ok && (cmd_q != '0);
      res_code_q  <= ok ? cmd_q : '0;
    end
  end

  // Output register: load when free or being drained, drop on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (act_i.emit && !out_busy) begin
      out_valid_o <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i.emit && !out_busy) begin
      busy_res_o   <= res_busy_q;
      frame_done_o <= res_done_q;
      code_valid_o <= res_valid_q;
      code_o       <= res_code_q;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nec_ir_sample_decoder_unit.sv @@
// Top level of the NEC infrared sample decoder.
// An ordinary sample is taken, classified and then emitted into the result register; the sample
// that ends a frame first walks the pulse store, with a read step and a check step for each
// of its 67 entries (one read port), then finishes and is emitted. A new sample is taken only
// after the previous result is emitted, so a stall on the result side also holds the input.
// Reset: asynchronous, active low; registers return to their defaults, capture goes idle.
`default_nettype none

module nec_ir_sample_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nisd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [nisd_pkg::DATA_W-1:0]     pwdata,
  output logic      [nisd_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [nisd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 busy_res_o,
  output logic                                 frame_done_o,
  output logic                                 code_valid_o,
  output logic      [nisd_pkg::CODE_W-1:0]     code_o
);
  import nisd_pkg::*;

  cfg_t    cfg;
  act_t    act;
  status_t status;

  nisd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nisd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .act_o    (act)
  );

  nisd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .act_i        (act),
    .status_o     (status),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .busy_res_o   (busy_res_o),
    .frame_done_o (frame_done_o),
    .code_valid_o (code_valid_o),
    .code_o       (code_o)
  );

endmodule

`default_nettype wire

@@ hdl/nisd_checker.sv @@
// Port-level checks for the NEC sample decoder, bound to the top level.
`default_nettype none

module nisd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        busy_res_o,
  input wire logic        frame_done_o,
  input wire logic        code_valid_o,
  input wire logic [31:0] code_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_o) && $stable(frame_done_o))
    else $error("stalled result changed");

  // one request at a time: no back-to-back input accepts
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_valid_o |-> frame_done_o && (code_o != 32'd0))
    else $error("valid code without frame end");

  a_valid_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_valid_o |-> code_o[31:24] == ~code_o[23:16])
    else $error("valid code fails inverse byte check");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !busy_res_o)
    else $error("busy on frame end");

endmodule

bind nec_ir_sample_decoder_unit nisd_checker u_nisd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .busy_res_o   (busy_res_o),
  .frame_done_o (frame_done_o),
  .code_valid_o (code_valid_o),
  .code_o       (code_o)
);

`default_nettype wire
